/* src/gf2_pivot_column_elimination_macros.svh */
// assertion macros for the gf2 pivot column elimination checker
// expects signals named clk and rst_n in the using scope
`ifndef GF2_PIVOT_COLUMN_ELIMINATION_MACROS_SVH
`define GF2_PIVOT_COLUMN_ELIMINATION_MACROS_SVH

// plain property, clocked on clk, off during reset
`define GF2PCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GF2PCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gf2pce_pkg.sv */
// shared types, codes and defaults for the gf2 pivot column elimination block
// no dependencies
package gf2pce_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int ROW_BITS_DEF = 64;
    localparam int NUM_COLS     = 64;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 7;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_PIVOT = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [2:0] ST_PIVOTED  = 3'd0;
    localparam logic [2:0] ST_NO_PIVOT = 3'd1;
    localparam logic [2:0] ST_TRIED    = 3'd2;
    localparam logic [2:0] ST_COMPLETE = 3'd3;
    localparam logic [2:0] ST_DONE_OK  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 4'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  row_index;
        logic [63:0] row_bits;
        logic [5:0]  column_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  pivot_row;
        logic [63:0] row_out;
        logic        row_has_pivot;
        logic [6:0]  pivots_done;
        logic        complete;
    } result_t;

    typedef struct packed {
        logic clear;
        logic col_set;
        logic row_set;
        logic count_inc;
    } marks_ctrl_t;

    typedef struct packed {
        logic       row_pivoted;
        logic       col_tried;
        logic [6:0] pivot_count;
    } marks_stat_t;

endpackage

/* src/gf2pce_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module gf2pce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/gf2pce_marks.sv */
// row pivot flags, column marks and pivot count
// depends on gf2pce_pkg
module gf2pce_marks import gf2pce_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  marks_ctrl_t                 ctrl,
    input  logic [$clog2(MAX_ROWS)-1:0] row_addr,
    input  logic [$clog2(MAX_ROWS)-1:0] set_addr,
    input  logic [NUM_COLS-1:0]         col_sel,
    output marks_stat_t                 stat
);

    logic [MAX_ROWS-1:0] row_pivoted_reg;
    logic [NUM_COLS-1:0] col_mark_reg;
    logic [6:0]          count_reg;

    // column marks keep only the tried flag, the only part ever tested
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pivoted_reg <= '0;
            col_mark_reg    <= '0;
            count_reg       <= '0;
        end
        else if (ctrl.clear)
        begin
            row_pivoted_reg <= '0;
            col_mark_reg    <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (ctrl.row_set)
            begin
                row_pivoted_reg[set_addr] <= 1'b1;
            end
            if (ctrl.col_set)
            begin
                col_mark_reg <= col_mark_reg | col_sel;
            end
            if (ctrl.count_inc)
            begin
                count_reg <= count_reg + 7'd1;
            end
        end
    end

    assign stat.row_pivoted = row_pivoted_reg[row_addr];
    assign stat.col_tried   = |(col_mark_reg & col_sel);
    assign stat.pivot_count = count_reg;

endmodule

/* src/gf2_pivot_column_elimination.sv */
// gf2 pivot column elimination, top level with sequencer
// depends on gf2pce_pkg, gf2pce_ram, gf2pce_marks
//
// usage: a command beat is taken when start is high and busy is low. load,
// clear and refused pivots give their result in the next cycle; a read first
// waits in S_RDWAIT for the registered row memory read. a pivot scans the
// rows in use, one row read a cycle from the row memory, until the first
// unpivoted row with a 1 in the column, then sweeps all rows in use again,
// each row read and then written back in the next cycle. the single read
// port of the row memory sets the pace of the scan and the sweep. one command
// is in flight at a time; the next can be taken at the edge that takes the
// result. each result beat shows on result for exactly one cycle with done
// high; the receiver cannot stall, so it must take it then.
// configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready high) and must come only while idle.
// reset clears flags, column marks, the pivot count and sets both registers
// to 64; row contents are undefined until loaded.
module gf2_pivot_column_elimination import gf2pce_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int ROW_BITS = ROW_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_t                  cmd,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RA = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RDWAIT = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_ELIM   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [6:0]            num_rows_reg, num_cols_reg;
    logic                  vld_q_reg, vld_q_next;
    logic                  inrange_reg, inrange_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         rows_reg, rows_next;
    logic [RA-1:0]         addr_q_reg, addr_q_next;
    logic [RA-1:0]         found_reg, found_next;
    logic [5:0]            col_reg, col_next;
    logic [ROW_BITS-1:0]   piv_reg, piv_next;
    result_t               res_reg, res_next, res_base;

    logic [CW-1:0]         eff_rows;
    logic [6:0]            eff_cols;
    logic [ROW_BITS-1:0]   cmask, colbit;
    logic [NUM_COLS-1:0]   col_oh;

    logic                  ram_we, ram_re;
    logic [RA-1:0]         ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0]   ram_wdata, ram_rdata;

    marks_ctrl_t           mctrl;
    marks_stat_t           mstat;

    logic                  hit, last, issue, in_range, col_ok;
    logic                  cnt_full, inc_full, zero_full;
    logic [6:0]            cnt, cnt_inc;

    gf2pce_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gf2pce_marks #(
        .MAX_ROWS (MAX_ROWS)
    ) u_marks (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mctrl),
        .row_addr (addr_q_reg),
        .set_addr (found_reg),
        .col_sel  (col_oh),
        .stat     (mstat)
    );

    assign eff_rows = (32'(num_rows_reg) < 32'(MAX_ROWS)) ? CW'(num_rows_reg) : CW'(MAX_ROWS);
    assign eff_cols = (32'(num_cols_reg) < 32'(ROW_BITS)) ? num_cols_reg : 7'(ROW_BITS);

    always_comb
    begin
        for (int j = 0; j < ROW_BITS; j++)
        begin
            cmask[j]  = 32'(j) < 32'(eff_cols);
            colbit[j] = col_reg == 6'(j);
        end
        for (int j = 0; j < NUM_COLS; j++)
        begin
            col_oh[j] = cmd.column_index == 6'(j);
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    assign cnt       = mstat.pivot_count;
    assign cnt_inc   = cnt + 7'd1;
    assign cnt_full  = 32'(cnt) == 32'(eff_rows);
    assign inc_full  = 32'(cnt_inc) == 32'(eff_rows);
    assign zero_full = eff_rows == '0;
    assign in_range  = 32'(cmd.row_index) < 32'(MAX_ROWS);
    assign col_ok    = 32'(cmd.column_index) < 32'(eff_cols);
    assign hit       = vld_q_reg && !mstat.row_pivoted && (|(ram_rdata & colbit));
    assign last      = (32'(addr_q_reg) + 32'd1) == 32'(rows_reg);
    assign issue     = 32'(idx_reg) < 32'(rows_reg);

    always_comb
    begin
        res_base.status        = ST_DONE_OK;
        res_base.pivot_row     = '0;
        res_base.row_out       = '0;
        res_base.row_has_pivot = 1'b0;
        res_base.pivots_done   = cnt;
        res_base.complete      = cnt_full;
    end

    always_comb
    begin
        state_next   = state_reg;
        vld_q_next   = vld_q_reg;
        inrange_next = inrange_reg;
        done_next    = 1'b0;
        idx_next     = idx_reg;
        rows_next    = rows_reg;
        addr_q_next  = addr_q_reg;
        found_next   = found_reg;
        col_next     = col_reg;
        piv_next     = piv_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = RA'(cmd.row_index);
        ram_wdata    = cmd.row_bits[ROW_BITS-1:0];
        ram_re       = 1'b0;
        ram_raddr    = RA'(idx_reg);
        mctrl        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = res_base;
                    case (cmd.action)
                        ACT_LOAD:
                        begin
                            ram_we    = in_range;
                            done_next = 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            mctrl.clear          = 1'b1;
                            res_next.pivots_done = '0;
                            res_next.complete    = zero_full;
                            done_next            = 1'b1;
                        end
                        ACT_READ:
                        begin
                            ram_re       = in_range;
                            ram_raddr    = RA'(cmd.row_index);
                            addr_q_next  = RA'(cmd.row_index);
                            inrange_next = in_range;
                            state_next   = S_RDWAIT;
                        end
                        ACT_PIVOT:
                        begin
                            if (32'(cnt) >= 32'(eff_rows))
                            begin
                                res_next.status = ST_COMPLETE;
                                done_next       = 1'b1;
                            end
                            else if (!col_ok)
                            begin
                                res_next.status = ST_NO_PIVOT;
                                done_next       = 1'b1;
                            end
                            else if (mstat.col_tried)
                            begin
                                res_next.status = ST_TRIED;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                mctrl.col_set = 1'b1;
                                col_next      = cmd.column_index;
                                rows_next     = eff_rows;
                                idx_next      = '0;
                                vld_q_next    = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_next               = res_base;
                res_next.row_out       = inrange_reg ? 64'(ram_rdata) : '0;
                res_next.row_has_pivot = inrange_reg && mstat.row_pivoted;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    // pivot found, start the sweep at row zero
                    found_next  = addr_q_reg;
                    piv_next    = ram_rdata;
                    ram_re      = 1'b1;
                    ram_raddr   = '0;
                    addr_q_next = '0;
                    idx_next    = CW'(1);
                    vld_q_next  = 1'b1;
                    state_next  = S_ELIM;
                end
                else if (vld_q_reg && last)
                begin
                    // column stays marked as tried
                    res_next        = res_base;
                    res_next.status = ST_NO_PIVOT;
                    done_next       = 1'b1;
                    vld_q_next      = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ram_re      = issue;
                    vld_q_next  = issue;
                    addr_q_next = RA'(idx_reg);
                    if (issue)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            S_ELIM:
            begin
                if (vld_q_reg && addr_q_reg != found_reg && (|(ram_rdata & colbit)))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_q_reg;
                    ram_wdata = ram_rdata ^ (piv_reg & cmask);
                end
                if (vld_q_reg && last)
                begin
                    mctrl.row_set        = 1'b1;
                    mctrl.count_inc      = 1'b1;
                    res_next             = res_base;
                    res_next.status      = ST_PIVOTED;
                    res_next.pivot_row   = 6'(found_reg);
                    res_next.pivots_done = cnt_inc;
                    res_next.complete    = inc_full;
                    done_next            = 1'b1;
                    vld_q_next           = 1'b0;
                    state_next           = S_IDLE;
                end
                else
                begin
                    ram_re      = issue;
                    vld_q_next  = issue;
                    addr_q_next = RA'(idx_reg);
                    if (issue)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vld_q_reg    <= 1'b0;
            done_reg     <= 1'b0;
            num_rows_reg <= 7'd64;
            num_cols_reg <= 7'd64;
        end
        else
        begin
            state_reg <= state_next;
            vld_q_reg <= vld_q_next;
            done_reg  <= done_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_NUM_ROWS: num_rows_reg <= cfg_data;
                    REG_NUM_COLS: num_cols_reg <= cfg_data;
                    default:      num_rows_reg <= num_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        inrange_reg <= inrange_next;
        idx_reg     <= idx_next;
        rows_reg    <= rows_next;
        addr_q_reg  <= addr_q_next;
        found_reg   <= found_next;
        col_reg     <= col_next;
        piv_reg     <= piv_next;
        res_reg     <= res_next;
    end

endmodule

/* src/gf2pce_checker.sv */
// port level checks for gf2_pivot_column_elimination, bound to the top level
// depends on gf2pce_pkg and gf2_pivot_column_elimination_macros.svh
`include "gf2_pivot_column_elimination_macros.svh"

module gf2pce_checker import gf2pce_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // an accepted beat either finishes next cycle or keeps the block busy
    `GF2PCE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted beat lost")
    `GF2PCE_ASSERT(a_done_not_busy, done |-> !busy, "result beat while busy")
    `GF2PCE_ASSERT(a_busy_ends_done, $fell(busy) |-> done, "busy ended without result beat")
    `GF2PCE_ASSERT(a_pivot_counts, (done && result.status == ST_PIVOTED) |-> (result.pivots_done != 7'd0), "pivot without count")

endmodule

bind gf2_pivot_column_elimination gf2pce_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* sim/gf2_pivot_column_elimination_checker.sv */
`timescale 1ns / 1ps
// result checker for gf2_pivot_column_elimination: mirrors the matrix, marks and registers
// depends on gf2pce_pkg; watches the command, result and configuration channels
module gf2_pivot_column_elimination_checker import gf2pce_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  cmd_t                  cmd,
    input  logic                  done,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    typedef enum logic [1:0] {COL_UNTRIED, COL_PIVOT, COL_REJECTED} col_state_e;

    logic [ROW_BITS_DEF-1:0] mat_row [MAX_ROWS_DEF];
    bit                      is_pivot_row [MAX_ROWS_DEF];
    col_state_e              col_state [NUM_COLS];
    logic [6:0]              pivots;
    logic [6:0]              rows_cfg;
    logic [6:0]              cols_cfg;
    result_t                 pending_results [$];
    result_t                 want;
    result_t                 next_res;

    function automatic int rows_in_use();
        return (rows_cfg < MAX_ROWS_DEF) ? int'(rows_cfg) : MAX_ROWS_DEF;
    endfunction

    function automatic int cols_in_use();
        return (cols_cfg < ROW_BITS_DEF) ? int'(cols_cfg) : ROW_BITS_DEF;
    endfunction

    task automatic clear_marks();
        foreach (is_pivot_row[i])
            is_pivot_row[i] = 1'b0;
        foreach (col_state[i])
            col_state[i] = COL_UNTRIED;
        pivots = '0;
    endtask

    task automatic pivot_on(input logic [5:0] col, output logic [2:0] st,
                            output logic [5:0] prow);
        int rows;
        int cols;
        int found;
        logic [63:0] sel;
        logic [63:0] cmask;
        rows  = rows_in_use();
        cols  = cols_in_use();
        sel   = 64'd1 << col;
        cmask = (cols >= 64) ? '1 : ((64'd1 << cols) - 64'd1);
        found = -1;
        prow  = '0;
        if (pivots >= rows)
            st = ST_COMPLETE;
        else if (col >= cols)
            st = ST_NO_PIVOT;
        else if (col_state[col] != COL_UNTRIED)
            st = ST_TRIED;
        else
        begin
            for (int i = 0; i < rows; i++)
                if (found < 0 && !is_pivot_row[i] && (mat_row[i] & sel) != '0)
                    found = i;
            if (found < 0)
            begin
                col_state[col] = COL_REJECTED;
                st = ST_NO_PIVOT;
            end
            else
            begin
                col_state[col] = COL_PIVOT;
                for (int i = 0; i < rows; i++)
                    if (i != found && (mat_row[i] & sel) != '0)
                        mat_row[i] = mat_row[i] ^ (mat_row[found] & cmask);
                is_pivot_row[found] = 1'b1;
                pivots = pivots + 7'd1;
                prow = 6'(found);
                st = ST_PIVOTED;
            end
        end
    endtask

    task automatic predict_result(input cmd_t c, output result_t r);
        r = '0;
        r.status = ST_DONE_OK;
        case (c.action)
            ACT_LOAD:  mat_row[c.row_index] = c.row_bits;
            ACT_CLEAR: clear_marks();
            ACT_PIVOT: pivot_on(c.column_index, r.status, r.pivot_row);
            default:
            begin
                r.row_out = mat_row[c.row_index];
                r.row_has_pivot = is_pivot_row[c.row_index];
            end
        endcase
        r.pivots_done = pivots;
        r.complete = (int'(pivots) == rows_in_use());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (mat_row[i])
                mat_row[i] = '0;
            clear_marks();
            rows_cfg = 7'd64;
            cols_cfg = 7'd64;
            pending_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat with nothing expected, status %0d",
                                 $realtime, result.status);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status || result.pivot_row !== want.pivot_row
                        || result.row_out !== want.row_out
                        || result.row_has_pivot !== want.row_has_pivot
                        || result.pivots_done !== want.pivots_done
                        || result.complete !== want.complete)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result mismatch (expected / actual)", $realtime);
                            $display("  status %0d / %0d  pivot_row %0d / %0d",
                                     want.status, result.status,
                                     want.pivot_row, result.pivot_row);
                            $display("  row_out %h / %h  row_has_pivot %0d / %0d",
                                     want.row_out, result.row_out,
                                     want.row_has_pivot, result.row_has_pivot);
                            $display("  pivots_done %0d / %0d  complete %0d / %0d",
                                     want.pivots_done, result.pivots_done,
                                     want.complete, result.complete);
                        end
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_result(cmd, next_res);
                pending_results.push_back(next_res);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_ROWS: rows_cfg = cfg_data;
                    REG_NUM_COLS: cols_cfg = cfg_data;
                    default: ;
                endcase
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* sim/tb_gf2_pivot_column_elimination.sv */
`timescale 1ns / 1ps
// testbench top for gf2_pivot_column_elimination: clock, reset, command and register stimulus
// depends on gf2pce_pkg, the block and gf2_pivot_column_elimination_checker
module tb_gf2_pivot_column_elimination;
    import gf2pce_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    cmd_t                  cmd;
    logic                  done;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    gap_pct;
    int                    cmds_sent;
    bit                    row_loaded [MAX_ROWS_DEF];

    gf2_pivot_column_elimination dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gf2_pivot_column_elimination_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("** gf2_pivot_column_elimination: FAILED **");
        $finish;
    end

    function automatic logic [63:0] rand_row();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2, 3, 4: v = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // returns at the accepting edge with start still high; wait_idle or write_reg drops it
    // at the following falling edge, while the next call may keep it high with a new command
    task automatic issue(input logic [1:0] act, input logic [5:0] ridx,
                         input logic [63:0] bits, input logic [5:0] col);
        cmd_t c;
        c.action = act;
        c.row_index = ridx;
        c.row_bits = bits;
        c.column_index = col;
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (act == ACT_LOAD)
            row_loaded[ridx] = 1'b1;
        cmds_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        start <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic random_op(input int nr, input int nc);
        int pick;
        int r;
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, 63);
        if (pick < 70)
            issue(ACT_PIVOT, 6'(r), {$urandom, $urandom},
                  (pick < 60) ? 6'($urandom_range(0, nc - 1)) : 6'($urandom_range(0, 63)));
        else if (pick < 85)
        begin
            if (!row_loaded[r])
                r = $urandom_range(0, nr - 1);
            issue(ACT_READ, 6'(r), {$urandom, $urandom}, 6'($urandom_range(0, 63)));
        end
        else if (pick < 95)
            issue(ACT_LOAD, 6'(r), rand_row(), 6'($urandom_range(0, 63)));
        else
            issue(ACT_CLEAR, 6'($urandom_range(0, 63)), {$urandom, $urandom},
                  6'($urandom_range(0, 63)));
    endtask

    // new register setting, fresh or partly kept matrix, then a run of random pivots, reads, loads and clears
    task automatic run_elimination();
        int nr;
        int nc;
        wait_idle();
        case ($urandom_range(0, 9))
            0:       nr = 1;
            1:       nr = 64;
            2:       nr = $urandom_range(33, 64);
            3, 4:    nr = $urandom_range(9, 32);
            default: nr = $urandom_range(2, 8);
        endcase
        case ($urandom_range(0, 7))
            0:       nc = 1;
            1:       nc = 64;
            2, 3:    nc = $urandom_range(1, 64);
            default: nc = $urandom_range(nr, (nr + 8 > 64) ? 64 : nr + 8);
        endcase
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_NUM_ROWS, nr);
            write_reg(REG_NUM_COLS, nc);
        end
        else
        begin
            write_reg(REG_NUM_COLS, nc);
            write_reg(REG_NUM_ROWS, nr);
        end
        if ($urandom_range(0, 3) != 0)
            issue(ACT_CLEAR, 6'($urandom_range(0, 63)), {$urandom, $urandom},
                  6'($urandom_range(0, 63)));
        for (int i = 0; i < nr; i++)
            if (!row_loaded[i] || $urandom_range(0, 3) != 0)
                issue(ACT_LOAD, 6'(i), rand_row(), 6'($urandom_range(0, 63)));
        repeat (nr + $urandom_range(2, 10))
            random_op(nr, nc);
    endtask

    initial
    begin
        int target;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gap_pct = 6;
        cmds_sent = 0;
        foreach (row_loaded[i])
            row_loaded[i] = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // small matrix, four rows by eight columns
        write_reg(REG_NUM_ROWS, 4);
        write_reg(REG_NUM_COLS, 8);
        issue(ACT_LOAD, 0, '1, 0);
        issue(ACT_LOAD, 1, '0, 63);
        issue(ACT_LOAD, 2, 64'hF0F0_F0F0_F0F0_F002, 0);
        issue(ACT_LOAD, 3, 64'h8000_0000_0000_0081, 0);
        issue(ACT_LOAD, 63, '1, 63);
        issue(ACT_PIVOT, 63, '1, 0);
        issue(ACT_PIVOT, 0, '0, 0);
        issue(ACT_PIVOT, 0, '0, 8);
        issue(ACT_PIVOT, 0, '0, 63);
        issue(ACT_PIVOT, 0, '0, 1);
        issue(ACT_PIVOT, 0, '0, 7);
        issue(ACT_PIVOT, 0, '0, 7);
        issue(ACT_PIVOT, 0, '0, 2);
        issue(ACT_PIVOT, 0, '0, 3);
        issue(ACT_LOAD, 1, 64'h10, 0);
        issue(ACT_PIVOT, 0, '0, 4);
        issue(ACT_PIVOT, 0, '0, 5);
        issue(ACT_READ, 0, '0, 0);
        issue(ACT_READ, 3, '0, 0);
        issue(ACT_READ, 63, '1, 63);
        issue(ACT_CLEAR, 0, '0, 0);
        issue(ACT_READ, 0, '0, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 6 : (phase == 1) ? 54 : 0;
            target = cmds_sent + 176;
            while (cmds_sent < target)
                run_elimination();
        end

        wait_idle();
        repeat (140) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** gf2_pivot_column_elimination: PASSED **");
        else
            $display("** gf2_pivot_column_elimination: FAILED **");
        $finish;
    end

endmodule
